>>> design/nsem_pkg.sv
// ----------------------------------------------------------------------------
// nsem_pkg
// Shared constants, codes and types for the named semaphore table.
// ----------------------------------------------------------------------------
`default_nettype none
package nsem_pkg;

    localparam int NUM_SEMA    = 128;
    localparam int MAX_NAME    = 127;
    localparam int NUM_CONN    = 16;
    localparam int CONN_SLOTS  = 16;

    localparam int NAME_STRIDE = MAX_NAME + 1;
    localparam int SLOT_W      = $clog2(NUM_SEMA);
    localparam int NAME_W      = $clog2(NAME_STRIDE);
    localparam int LEN_W       = $clog2(NAME_STRIDE + 1);
    localparam int CONN_W      = $clog2(NUM_CONN);
    localparam int CDIST_W     = $clog2(CONN_SLOTS + 1);
    localparam int COPEN_AW    = CONN_W + SLOT_W;
    localparam int NSTORE_AW   = SLOT_W + NAME_W;

    localparam int OP_W        = 3;
    localparam int CONN_IN_W   = 4;
    localparam int BYTE_W      = 8;
    localparam int HANDLE_W    = 32;
    localparam int HOUT_W      = 8;
    localparam int VALUE_W     = 15;
    localparam int CNT_W       = 8;
    localparam int ST_W        = 3;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam logic [BYTE_W-1:0]  INIT_MAX  = 8'd127;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    localparam logic [OP_W-1:0] OP_NAME    = 3'd0;
    localparam logic [OP_W-1:0] OP_OPEN    = 3'd1;
    localparam logic [OP_W-1:0] OP_EXAMINE = 3'd2;
    localparam logic [OP_W-1:0] OP_WAIT    = 3'd3;
    localparam logic [OP_W-1:0] OP_SIGNAL  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLOSE   = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd1;
    localparam logic [ST_W-1:0] ST_BADLEN  = 3'd2;
    localparam logic [ST_W-1:0] ST_BADVAL  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;
    localparam logic [ST_W-1:0] ST_HANDLE  = 3'd5;
    localparam logic [ST_W-1:0] ST_UNAVAIL = 3'd6;
    localparam logic [ST_W-1:0] ST_SAT     = 3'd7;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [HOUT_W-1:0]  handle_out;
        logic [VALUE_W-1:0] value_out;
        logic [CNT_W-1:0]   open_count;
    } t_res;

endpackage
`default_nettype wire

>>> design/nsem_if.sv
// ----------------------------------------------------------------------------
// nsem_req_if / nsem_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface nsem_req_if import nsem_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [CONN_IN_W-1:0] conn;
    logic [BYTE_W-1:0]    name_byte;
    logic [BYTE_W-1:0]    init_value;
    logic [HANDLE_W-1:0]  handle;
    modport source (output valid, op, conn, name_byte, init_value, handle, input ready);
    modport sink   (input valid, op, conn, name_byte, init_value, handle, output ready);
endinterface

interface nsem_rsp_if import nsem_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [HOUT_W-1:0]  handle_out;
    logic [VALUE_W-1:0] value_out;
    logic [CNT_W-1:0]   open_count;
    modport source (output valid, status, handle_out, value_out, open_count, input ready);
    modport sink   (input valid, status, handle_out, value_out, open_count, output ready);
endinterface
`default_nettype wire

>>> design/nsem_ram.sv
// ----------------------------------------------------------------------------
// nsem_ram
// Simple dual-port RAM: one write, one read, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module nsem_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> design/nsem_seq.sv
// ----------------------------------------------------------------------------
// nsem_seq
// Sequencer: read-modify-write over the semaphore and name memories.
// ----------------------------------------------------------------------------
`default_nettype none
module nsem_seq import nsem_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nsem_req_if.sink  i_req,
    output logic      o_res_valid,
    output t_res      o_res,
    input  wire logic i_res_ready
);
    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISP     = 4'd2;
    localparam logic [3:0] S_RMW      = 4'd3;
    localparam logic [3:0] S_CLOSE    = 4'd4;
    localparam logic [3:0] S_CLR_RD   = 4'd5;
    localparam logic [3:0] S_CLR_WR   = 4'd6;
    localparam logic [3:0] S_SCAN     = 4'd7;
    localparam logic [3:0] S_LEN      = 4'd8;
    localparam logic [3:0] S_CMP      = 4'd9;
    localparam logic [3:0] S_RESOLVE  = 4'd10;
    localparam logic [3:0] S_OPEN_CHK = 4'd11;
    localparam logic [3:0] S_COPY_RD  = 4'd12;
    localparam logic [3:0] S_COPY_WR  = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    localparam logic [SLOT_W:0] SCAN_END = (SLOT_W+1)'(NUM_SEMA);
    localparam logic [SLOT_W:0] SCAN_LST = (SLOT_W+1)'(NUM_SEMA - 1);

    logic [3:0]            r_state;
    logic [OP_W-1:0]       r_op;
    logic [CONN_W-1:0]     r_conn;
    logic [BYTE_W-1:0]     r_name_byte;
    logic [BYTE_W-1:0]     r_init;
    logic [HANDLE_W-1:0]   r_handle;
    logic [SLOT_W-1:0]     r_slot;
    logic [SLOT_W:0]       r_s;
    logic [LEN_W-1:0]      r_k;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      r_plen;
    logic [SLOT_W-1:0]     r_hit;
    logic [SLOT_W-1:0]     r_fr;
    logic                  r_hit_ok;
    logic                  r_fr_ok;
    logic [COPEN_AW-1:0]   r_iaddr;
    logic [NUM_SEMA-1:0]   r_valid;
    logic [CDIST_W-1:0]    r_cdist [NUM_CONN];
    t_res                  r_res;

    // memory ports
    logic                  sval_we,  sopen_we,  nlen_we,  copen_we,  pname_we,  nstore_we;
    logic [SLOT_W-1:0]     sval_wa,  sopen_wa,  nlen_wa,  rd_slot;
    logic [VALUE_W-1:0]    sval_wd,  sval_rd;
    logic [CNT_W-1:0]      sopen_wd, sopen_rd, copen_wd, copen_rd;
    logic [LEN_W-1:0]      nlen_rd;
    logic [COPEN_AW-1:0]   copen_wa;
    logic [NAME_W-1:0]     pname_wa, pname_ra;
    logic [BYTE_W-1:0]     pname_rd, nstore_rd;
    logic [NSTORE_AW-1:0]  nstore_wa;

    logic [SLOT_W-1:0]     h_slot, sel_slot, s_idx;
    logic                  h_ok, open_ok, in_take;
    logic [CDIST_W-1:0]    cdist_c;

    assign s_idx    = r_s[SLOT_W-1:0];
    assign h_slot   = SLOT_W'(r_handle - HANDLE_W'(1));
    assign h_ok     = (r_handle != '0) && (r_handle <= HANDLE_W'(NUM_SEMA)) && r_valid[h_slot];
    assign sel_slot = r_hit_ok ? r_hit : r_fr;
    assign cdist_c  = r_cdist[r_conn];
    assign open_ok  = !((copen_rd == '0) && (cdist_c >= CDIST_W'(CONN_SLOTS)))
                   && !(r_hit_ok && ((sopen_rd == CNT_MAX) || (copen_rd == CNT_MAX)));

    assign i_req.ready = (r_state == S_IDLE);
    assign in_take     = i_req.valid && i_req.ready;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // read addresses
    always_comb begin
        case (r_state)
            S_DISP:    rd_slot = h_slot;
            S_RESOLVE: rd_slot = sel_slot;
            default:   rd_slot = s_idx;
        endcase
        case (r_state)
            S_COPY_RD: pname_ra = r_k[NAME_W-1:0];
            S_CMP:     pname_ra = r_k[NAME_W-1:0] + NAME_W'(1);
            default:   pname_ra = '0;
        endcase
    end

    // write ports
    always_comb begin
        sval_we   = 1'b0; sval_wa  = r_slot; sval_wd  = VALUE_W'(r_init);
        sopen_we  = 1'b0; sopen_wa = r_slot; sopen_wd = CNT_W'(1);
        nlen_we   = 1'b0; nlen_wa  = r_slot;
        copen_we  = 1'b0; copen_wa = {r_conn, r_slot}; copen_wd = '0;
        pname_we  = 1'b0; pname_wa = r_plen[NAME_W-1:0];
        nstore_we = 1'b0; nstore_wa = {r_slot, r_k[NAME_W-1:0]};
        case (r_state)
            S_INIT: begin
                copen_we = 1'b1;
                copen_wa = r_iaddr;
            end
            S_DISP: begin
                pname_we = (r_op == OP_NAME) && (r_plen < LEN_W'(MAX_NAME));
            end
            S_RMW: begin
                if (r_op == OP_WAIT && sval_rd != '0) begin
                    sval_we = 1'b1;
                    sval_wd = sval_rd - VALUE_W'(1);
                end else if (r_op == OP_SIGNAL && sval_rd != VALUE_MAX) begin
                    sval_we = 1'b1;
                    sval_wd = sval_rd + VALUE_W'(1);
                end
            end
            S_CLOSE: begin
                if (copen_rd != '0) begin
                    copen_we = 1'b1;
                    copen_wd = copen_rd - CNT_W'(1);
                    sopen_we = (sopen_rd > CNT_W'(1));
                    sopen_wd = sopen_rd - CNT_W'(1);
                end
            end
            S_CLR_WR: begin
                copen_wa = {r_conn, s_idx};
                sopen_wa = s_idx;
                if (copen_rd != '0) begin
                    copen_we = 1'b1;
                    sopen_we = r_valid[s_idx] && (sopen_rd > copen_rd);
                    sopen_wd = sopen_rd - copen_rd;
                end
            end
            S_OPEN_CHK: begin
                if (open_ok) begin
                    copen_we = 1'b1;
                    copen_wd = copen_rd + CNT_W'(1);
                    sopen_we = 1'b1;
                    if (r_hit_ok) begin
                        sopen_wd = sopen_rd + CNT_W'(1);
                    end else begin
                        sval_we = 1'b1;
                        nlen_we = 1'b1;
                    end
                end
            end
            S_COPY_WR: begin
                nstore_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    nsem_ram #(.DEPTH(NUM_SEMA), .WIDTH(VALUE_W)) u_sval (
        .i_clk, .i_we(sval_we), .i_waddr(sval_wa), .i_wdata(sval_wd),
        .i_raddr(rd_slot), .o_rdata(sval_rd));
    nsem_ram #(.DEPTH(NUM_SEMA), .WIDTH(CNT_W)) u_sopen (
        .i_clk, .i_we(sopen_we), .i_waddr(sopen_wa), .i_wdata(sopen_wd),
        .i_raddr(rd_slot), .o_rdata(sopen_rd));
    nsem_ram #(.DEPTH(NUM_SEMA), .WIDTH(LEN_W)) u_nlen (
        .i_clk, .i_we(nlen_we), .i_waddr(nlen_wa), .i_wdata(r_len),
        .i_raddr(s_idx), .o_rdata(nlen_rd));
    nsem_ram #(.DEPTH(NUM_CONN * NUM_SEMA), .WIDTH(CNT_W)) u_copen (
        .i_clk, .i_we(copen_we), .i_waddr(copen_wa), .i_wdata(copen_wd),
        .i_raddr({r_conn, rd_slot}), .o_rdata(copen_rd));
    nsem_ram #(.DEPTH(NAME_STRIDE), .WIDTH(BYTE_W)) u_pname (
        .i_clk, .i_we(pname_we), .i_waddr(pname_wa), .i_wdata(r_name_byte),
        .i_raddr(pname_ra), .o_rdata(pname_rd));
    nsem_ram #(.DEPTH(NUM_SEMA * NAME_STRIDE), .WIDTH(BYTE_W)) u_nstore (
        .i_clk, .i_we(nstore_we), .i_waddr(nstore_wa), .i_wdata(pname_rd),
        .i_raddr({s_idx, pname_ra}), .o_rdata(nstore_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_iaddr  <= '0;
            r_valid  <= '0;
            r_plen   <= '0;
            r_conn   <= '0;
            r_hit_ok <= 1'b0;
            r_fr_ok  <= 1'b0;
            for (int c = 0; c < NUM_CONN; c++) begin
                r_cdist[c] <= '0;
            end
        end else begin
            case (r_state)
                S_INIT: begin
                    r_iaddr <= r_iaddr + COPEN_AW'(1);
                    if (r_iaddr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_take) begin
                        r_op        <= i_req.op;
                        r_conn      <= CONN_W'(i_req.conn);
                        r_name_byte <= i_req.name_byte;
                        r_init      <= i_req.init_value;
                        r_handle    <= i_req.handle;
                        r_res       <= '0;
                        r_state     <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_slot  <= h_slot;
                    r_s     <= '0;
                    r_state <= S_DONE;
                    case (r_op)
                        OP_NAME: begin
                            if (r_plen <= LEN_W'(MAX_NAME)) begin
                                r_plen <= r_plen + LEN_W'(1);
                            end
                        end
                        OP_OPEN: begin
                            r_len    <= r_plen;
                            r_plen   <= '0;
                            r_hit_ok <= 1'b0;
                            r_fr_ok  <= 1'b0;
                            if (r_plen == '0 || r_plen > LEN_W'(MAX_NAME)) begin
                                r_res.status <= ST_BADLEN;
                            end else if (r_init > INIT_MAX) begin
                                r_res.status <= ST_BADVAL;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        OP_EXAMINE, OP_WAIT, OP_SIGNAL, OP_CLOSE: begin
                            if (!h_ok) begin
                                r_res.status <= ST_HANDLE;
                            end else if (r_op == OP_CLOSE) begin
                                r_state <= S_CLOSE;
                            end else begin
                                r_state <= S_RMW;
                            end
                        end
                        OP_CLEAR: r_state <= S_CLR_RD;
                        default:  r_res.status <= ST_UNKNOWN;
                    endcase
                end
                S_RMW: begin
                    r_state <= S_DONE;
                    if (r_op == OP_EXAMINE) begin
                        r_res.value_out  <= sval_rd;
                        r_res.open_count <= sopen_rd;
                    end else if (r_op == OP_WAIT && sval_rd == '0) begin
                        r_res.status <= ST_UNAVAIL;
                    end
                end
                S_CLOSE: begin
                    r_state <= S_DONE;
                    if (copen_rd == '0) begin
                        r_res.status <= ST_HANDLE;
                    end else begin
                        if (copen_rd == CNT_W'(1) && cdist_c != '0) begin
                            r_cdist[r_conn] <= cdist_c - CDIST_W'(1);
                        end
                        if (sopen_rd <= CNT_W'(1)) begin
                            r_valid[r_slot] <= 1'b0;
                        end
                    end
                end
                S_CLR_RD: r_state <= S_CLR_WR;
                S_CLR_WR: begin
                    if (copen_rd != '0 && r_valid[s_idx] && sopen_rd <= copen_rd) begin
                        r_valid[s_idx] <= 1'b0;
                    end
                    r_s <= r_s + (SLOT_W+1)'(1);
                    if (r_s == SCAN_LST) begin
                        r_cdist[r_conn] <= '0;
                        r_state         <= S_DONE;
                    end else begin
                        r_state <= S_CLR_RD;
                    end
                end
                S_SCAN: begin
                    if (r_s == SCAN_END) begin
                        r_state <= S_RESOLVE;
                    end else if (r_valid[s_idx]) begin
                        r_state <= S_LEN;
                    end else begin
                        if (!r_fr_ok) begin
                            r_fr    <= s_idx;
                            r_fr_ok <= 1'b1;
                        end
                        r_s <= r_s + (SLOT_W+1)'(1);
                    end
                end
                S_LEN: begin
                    r_k <= '0;
                    if (nlen_rd == r_len) begin
                        r_state <= S_CMP;
                    end else begin
                        r_s     <= r_s + (SLOT_W+1)'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_CMP: begin
                    if (pname_rd != nstore_rd) begin
                        r_s     <= r_s + (SLOT_W+1)'(1);
                        r_state <= S_SCAN;
                    end else if (r_k == r_len - LEN_W'(1)) begin
                        r_hit    <= s_idx;
                        r_hit_ok <= 1'b1;
                        r_state  <= S_RESOLVE;
                    end else begin
                        r_k <= r_k + LEN_W'(1);
                    end
                end
                S_RESOLVE: begin
                    r_slot <= sel_slot;
                    if (!r_hit_ok && !r_fr_ok) begin
                        r_res.status <= ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_OPEN_CHK;
                    end
                end
                S_OPEN_CHK: begin
                    r_state <= S_DONE;
                    if ((copen_rd == '0) && (cdist_c >= CDIST_W'(CONN_SLOTS))) begin
                        r_res.status <= ST_FULL;
                    end else if (!open_ok) begin
                        r_res.status <= ST_SAT;
                    end else begin
                        if (copen_rd == '0) begin
                            r_cdist[r_conn] <= cdist_c + CDIST_W'(1);
                        end
                        r_res.handle_out <= HOUT_W'(r_slot) + HOUT_W'(1);
                        if (r_hit_ok) begin
                            r_res.open_count <= sopen_rd + CNT_W'(1);
                        end else begin
                            r_res.open_count <= CNT_W'(1);
                            r_valid[r_slot]  <= 1'b1;
                            r_k              <= '0;
                            r_state          <= S_COPY_RD;
                        end
                    end
                end
                S_COPY_RD: r_state <= S_COPY_WR;
                S_COPY_WR: begin
                    r_k <= r_k + LEN_W'(1);
                    if (r_k + LEN_W'(1) == r_len) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_COPY_RD;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= LEN_W'(MAX_NAME + 1))
        else $error("pending name length overran");
    a_take_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state == S_DISP)
        else $error("accepted beat not dispatched");
    a_cdist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_INIT |-> cdist_c <= CDIST_W'(CONN_SLOTS))
        else $error("connection slot count overran");
    a_copy_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nstore_we |-> r_valid[r_slot])
        else $error("name copied into a free slot");
endmodule
`default_nettype wire

>>> design/named_counting_semaphore_table.sv
// ----------------------------------------------------------------------------
// named_counting_semaphore_table
// Table of named counting semaphores shared by several connections.
// ----------------------------------------------------------------------------
// Usage:
//  - i_req carries one request beat (op, conn, name_byte, init_value,
//    handle); o_rsp returns exactly one response beat per request, in order.
//  - A name is streamed in with name-byte beats, then an open beat matches
//    it against live entries or takes the lowest free slot.
//  - One request is worked on at a time. Name bytes, unknown ops and
//    rejected handles are answered at dispatch; examine/wait/signal/
//    close first read the slot; clear connection reads and writes back
//    each slot in turn; open scans the slots, comparing the stored name
//    of each live entry of the same length byte by byte, then copies the
//    name byte by byte into a new entry.
//  - After reset all NUM_CONN*NUM_SEMA (2048) per-connection open counts
//    are swept to zero, with i_req.ready low.
//  - The response sits in an output register; a new request is accepted
//    while it waits. If the receiver stalls, the next result is held in the
//    sequencer until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
module named_counting_semaphore_table import nsem_pkg::*; (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    nsem_req_if.sink   i_req,
    nsem_rsp_if.source o_rsp
);
    logic res_valid;
    logic res_ready;
    t_res res;
    logic r_ovalid;
    t_res r_out;

    nsem_seq u_seq (
        .i_clk,
        .i_rst_n,
        .i_req,
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output register takes a result whenever it is empty or being drained
    assign res_ready = !r_ovalid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= (res_valid && res_ready) || (r_ovalid && !o_rsp.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.handle_out = r_out.handle_out;
    assign o_rsp.value_out  = r_out.value_out;
    assign o_rsp.open_count = r_out.open_count;
endmodule
`default_nettype wire
